@@ hw/rtl/mfpc_pkg.sv @@
// ----------------------------------------------------------------------------
// mfpc_pkg: shared definitions for the minimum falling path cost block
// Matrix geometry, field widths and the result payload type.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpc_pkg;

   localparam int MATRIX_SIZE = 16;
   localparam int COST_BITS   = 16;

   localparam int COST_W  = 16;
   localparam int PATH_W  = 20;
   localparam int POS_W   = 4;
   localparam int IDX_W   = $clog2(MATRIX_SIZE);

   localparam logic [COST_W-1:0] COST_MASK =
      (COST_BITS >= COST_W) ? {COST_W{1'b1}} : COST_W'((64'd1 << COST_BITS) - 64'd1);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MATRIX_SIZE - 1);
   localparam logic [PATH_W-1:0] PATH_MAX  = {PATH_W{1'b1}};

   // CSR register indexes (word address)
   localparam logic REG_QUERY_ROW = 1'b0;
   localparam logic REG_QUERY_COL = 1'b1;

   typedef struct packed {
      logic [PATH_W-1:0] path_cost;
      logic [POS_W-1:0]  cell_row;
      logic [POS_W-1:0]  cell_col;
      logic              selected;
      logic              matrix_done;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/mfpc_req_if.sv @@
// ----------------------------------------------------------------------------
// mfpc_req_if: input channel
// One matrix cell per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfpc_req_if;
   logic                         valid;
   logic                         ready;
   logic [mfpc_pkg::COST_W-1:0]  cell_cost;
   logic                         start_matrix;

   modport source (output valid, output cell_cost, output start_matrix, input ready);
   modport sink   (input valid, input cell_cost, input start_matrix, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mfpc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mfpc_rsp_if: result channel
// One path cost result per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfpc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mfpc_pkg::PATH_W-1:0]  path_cost;
   logic [mfpc_pkg::POS_W-1:0]   cell_row;
   logic [mfpc_pkg::POS_W-1:0]   cell_col;
   logic                         selected;
   logic                         matrix_done;

   modport source (output valid, output path_cost, output cell_row, output cell_col,
                   output selected, output matrix_done, input ready);
   modport sink   (input valid, input path_cost, input cell_row, input cell_col,
                   input selected, input matrix_done, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mfpc_cell.sv @@
// ----------------------------------------------------------------------------
// mfpc_cell: one stage of the previous-row shift chain
// Holds one path cost and takes its neighbor's value (the new path cost at the tail) on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpc_cell (
   input  wire logic                         clock,
   input  wire logic                         shift_en,
   input  wire logic [mfpc_pkg::PATH_W-1:0]  cost_in,
   output      logic [mfpc_pkg::PATH_W-1:0]  cost_out
);

   logic [mfpc_pkg::PATH_W-1:0] cost_ff;
   logic [mfpc_pkg::PATH_W-1:0] cost_in_mux;

   assign cost_in_mux = shift_en ? cost_in : cost_ff;

   always_ff @(posedge clock) begin
      cost_ff <= cost_in_mux;
   end

   assign cost_out = cost_ff;

endmodule

`default_nettype wire

@@ hw/rtl/min_falling_path_cost.sv @@
// ----------------------------------------------------------------------------
// min_falling_path_cost: streamed minimum falling path sum
// Cost matrix in row-major order, one cell in, one path cost out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one matrix cell per transaction; start_matrix marks row 0,
//   column 0 of a new matrix. Without it the row and column counters wrap
//   after the last cell. rsp_chan returns one result per cell: path cost,
//   cell position, the selected flag for the cell named by the CSRs, and a
//   done flag on the last cell.
//   One cell is accepted every cycle unless rsp_chan is stalled; the
//   previous row lives in a chain of MATRIX_SIZE cells that shifts once
//   per accepted cell, so the up and up-right neighbors always sit in the
//   first two cells of the chain.
//   A single output register separates the channels: a new cell is taken
//   while the receiver holds the current result, as long as that result is
//   taken in the same cycle. While rsp_chan is stalled, req_chan.ready drops
//   and the chain and counters hold.
//   Reset clears the counters, the held left neighbor, the query registers
//   and the output valid. The chain is filled by row 0 of each matrix.
//   CSRs: query_row at byte 0, query_col at byte 4, APB writes, pready high.
// ----------------------------------------------------------------------------
`default_nettype none

module min_falling_path_cost (
   input  wire logic        clock,
   input  wire logic        reset,
   mfpc_req_if.sink         req_chan,
   mfpc_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int N     = mfpc_pkg::MATRIX_SIZE;
   localparam int IDX_W = mfpc_pkg::IDX_W;
   localparam int PW    = mfpc_pkg::PATH_W;
   localparam int QW    = mfpc_pkg::POS_W;

   // ---------------------------------------------------------------- CSRs
   logic [QW-1:0] query_row_ff, query_row_in;
   logic [QW-1:0] query_col_ff, query_col_in;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      query_row_in = query_row_ff;
      query_col_in = query_col_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            mfpc_pkg::REG_QUERY_ROW: query_row_in = csr_pwdata[QW-1:0];
            mfpc_pkg::REG_QUERY_COL: query_col_in = csr_pwdata[QW-1:0];
            default:                 query_row_in = query_row_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mfpc_pkg::REG_QUERY_ROW: csr_prdata = {{(32-QW){1'b0}}, query_row_ff};
         mfpc_pkg::REG_QUERY_COL: csr_prdata = {{(32-QW){1'b0}}, query_col_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------ handshake
   logic accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // ------------------------------------------------------------- counters
   logic [IDX_W-1:0] row_ff, row_in, row_cur;
   logic [IDX_W-1:0] col_ff, col_in, col_cur;

   assign row_cur = req_chan.start_matrix ? '0 : row_ff;
   assign col_cur = req_chan.start_matrix ? '0 : col_ff;

   // ---------------------------------------------------------- shift chain
   logic [PW-1:0] chain_q [N];
   logic [PW-1:0] path_cost;

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_cell
         if (k == N - 1) begin : g_tail
            mfpc_cell u_cell (
               .clock    (clock),
               .shift_en (accept),
               .cost_in  (path_cost),
               .cost_out (chain_q[k])
            );
         end else begin : g_body
            mfpc_cell u_cell (
               .clock    (clock),
               .shift_en (accept),
               .cost_in  (chain_q[k+1]),
               .cost_out (chain_q[k])
            );
         end
      end
   endgenerate

   // ---------------------------------------------------------- path cost
   logic [PW-1:0] held_left_ff, held_left_in;
   logic [PW-1:0] best_a, best;
   logic [PW:0]   cost_ext;
   logic [PW:0]   sum;

   assign cost_ext = (PW+1)'(req_chan.cell_cost & mfpc_pkg::COST_MASK);

   always_comb begin
      best_a = chain_q[0];
      if (col_cur != '0 && held_left_ff < best_a) begin
         best_a = held_left_ff;
      end
      best = best_a;
      if (col_cur != mfpc_pkg::LAST_IDX && chain_q[1] < best_a) begin
         best = chain_q[1];
      end
   end

   assign sum = {1'b0, best} + cost_ext;

   always_comb begin
      if (row_cur == '0) begin
         path_cost = cost_ext[PW-1:0];
      end else if (sum[PW]) begin
         path_cost = mfpc_pkg::PATH_MAX;
      end else begin
         path_cost = sum[PW-1:0];
      end
   end

   // ------------------------------------------------------- next state
   logic [IDX_W+QW-1:0] row_wide, col_wide;
   mfpc_pkg::result_type result_ff, result_in;

   assign row_wide = {{QW{1'b0}}, row_cur};
   assign col_wide = {{QW{1'b0}}, col_cur};

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      held_left_in = held_left_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         held_left_in = chain_q[0];
         if (col_cur == mfpc_pkg::LAST_IDX) begin
            col_in = '0;
            row_in = (row_cur == mfpc_pkg::LAST_IDX) ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
         result_in.path_cost   = path_cost;
         result_in.cell_row    = row_wide[QW-1:0];
         result_in.cell_col    = col_wide[QW-1:0];
         result_in.selected    = (row_wide == (IDX_W+QW)'(query_row_ff)) &&
                                 (col_wide == (IDX_W+QW)'(query_col_ff));
         result_in.matrix_done = (row_cur == mfpc_pkg::LAST_IDX) &&
                                 (col_cur == mfpc_pkg::LAST_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_row_ff <= '0;
         query_col_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         held_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         query_row_ff <= query_row_in;
         query_col_ff <= query_col_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         held_left_ff <= held_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload without reset
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.path_cost   = result_ff.path_cost;
   assign rsp_chan.cell_row    = result_ff.cell_row;
   assign rsp_chan.cell_col    = result_ff.cell_col;
   assign rsp_chan.selected    = result_ff.selected;
   assign rsp_chan.matrix_done = result_ff.matrix_done;

endmodule

`default_nettype wire
